/* hdl/psd_pkg.sv */
package psd_pkg;

   // Control flags that travel with every item along the pipeline.
   typedef struct packed {
      logic valid;
      logic degenerate;
      logic t_one;
   } psd_ctrl_type;

endpackage

/* hdl/psd_stream_if.sv */
// Request channel: one segment and one query point per transaction.
interface psd_req_if #(
   parameter int COORD_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic signed [COORD_WIDTH-1:0] query_x;
   logic signed [COORD_WIDTH-1:0] query_y;

   modport source (output valid, start_x, start_y, end_x, end_y, query_x, query_y,
                   input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, query_x, query_y,
                   output ready);
endinterface

// Response channel: one distance result per transaction.
interface psd_rsp_if #(
   parameter int COORD_WIDTH = 24,
   parameter int T_FRAC_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH:0]   distance;
   logic [T_FRAC_BITS:0]   param_t;
   logic                   degenerate;

   modport source (output valid, distance, param_t, degenerate, input ready);
   modport sink   (input valid, distance, param_t, degenerate, output ready);
endinterface

/* hdl/point_segment_distance_unit.sv */
// Point to segment distance unit.
// The request channel carries a segment (start, end) and a query point, all
// signed fixed point with twelve fraction bits. The response channel returns
// the distance to the nearest point of the segment, the clamped projection
// parameter param_t (2**T_FRAC_BITS means 1.0) and a degenerate flag that is
// set when both endpoints coincide, in which case param_t is zero.
// One transaction is accepted per cycle unless the receiver stalls, and results leave in request order.
// The pipeline holds a row of division cells (one quotient bit each) and a
// row of square root cells (one root bit each), with seven arithmetic stages
// and the output register around them. The number of root bits is
// R = 2*ceil((COORD_WIDTH+T_FRAC_BITS+3)/2) + 1 - T_FRAC_BITS, which is 29
// with the default widths.
// The whole pipeline advances together whenever the output register is empty
// or being read; if the receiver stalls, the pipeline holds and req ready
// falls, and no transaction is lost. Synchronous reset empties every stage.
module point_segment_distance_unit #(
   parameter int COORD_WIDTH = 24,
   parameter int T_FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   psd_req_if.sink      req_chan,
   psd_rsp_if.source    rsp_chan
);

   localparam int CW  = COORD_WIDTH;
   localparam int T   = T_FRAC_BITS;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int LW  = 2 * CW + 2;
   localparam int SIDE_W = 4 * DW;
   localparam int TPW = T + 2 + DW;
   localparam int EW  = CW + T + 3;
   localparam int MW  = EW;
   localparam int H   = (MW + 1) / 2;
   localparam int D2W = 4 * H + 2;
   localparam int RW  = 2 * H + 1 - T;

   localparam logic [T:0]  T_ONE    = (T+1)'(1) << T;
   localparam logic [CW:0] DIST_MAX = '1;

   logic en;
   logic out_valid_ff;

   assign en = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 1: coordinate differences.
   logic                 s1_valid_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_px_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff <= DW'(req_chan.end_x)   - DW'(req_chan.start_x);
         s1_dy_ff <= DW'(req_chan.end_y)   - DW'(req_chan.start_y);
         s1_px_ff <= DW'(req_chan.query_x) - DW'(req_chan.start_x);
         s1_py_ff <= DW'(req_chan.query_y) - DW'(req_chan.start_y);
      end
   end

   // Stage 2: the four products for the dot product and squared length.
   logic                 s2_valid_ff;
   logic signed [PW-1:0] s2_pxdx_ff, s2_pydy_ff, s2_dxdx_ff, s2_dydy_ff;
   logic [SIDE_W-1:0]    s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pxdx_ff <= s1_px_ff * s1_dx_ff;
         s2_pydy_ff <= s1_py_ff * s1_dy_ff;
         s2_dxdx_ff <= s1_dx_ff * s1_dx_ff;
         s2_dydy_ff <= s1_dy_ff * s1_dy_ff;
         s2_side_ff <= {s1_dx_ff, s1_dy_ff, s1_px_ff, s1_py_ff};
      end
   end

   // Stage 3: sums and classification; set up the division row.
   logic signed [PW:0] dot;
   logic [LW-1:0]      len2;
   logic               is_degen, is_nonpos, is_past, is_div;

   always_comb begin
      dot       = (PW+1)'(s2_pxdx_ff) + (PW+1)'(s2_pydy_ff);
      len2      = LW'(s2_dxdx_ff) + LW'(s2_dydy_ff);
      is_degen  = (len2 == '0);
      is_nonpos = dot[PW] || (dot == '0);
      is_past   = !is_degen && !is_nonpos && ({1'b0, dot[PW-1:0]} >= (PW)'(len2));
      is_div    = !is_degen && !is_nonpos && !is_past;
   end

   psd_pkg::psd_ctrl_type div_ctrl [0:T];
   logic [LW-1:0]         div_rem  [0:T];
   logic [LW-1:0]         div_len  [0:T];
   logic [T-1:0]          div_quo  [0:T];
   logic [SIDE_W-1:0]     div_side [0:T];
   psd_pkg::psd_ctrl_type s3_ctrl_ff;
   logic [LW-1:0]         s3_rem_ff, s3_len_ff;
   logic [SIDE_W-1:0]     s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff <= '0;
      end else if (en) begin
         s3_ctrl_ff.valid      <= s2_valid_ff;
         s3_ctrl_ff.degenerate <= is_degen;
         s3_ctrl_ff.t_one      <= is_past;
      end
   end

   // Items that need no division get an unreachable divisor and zero remainder.
   always_ff @(posedge clock) begin
      if (en) begin
         s3_rem_ff  <= is_div ? LW'(dot) : '0;
         s3_len_ff  <= is_div ? len2 : '1;
         s3_side_ff <= s2_side_ff;
      end
   end

   assign div_ctrl[0] = s3_ctrl_ff;
   assign div_rem[0]  = s3_rem_ff;
   assign div_len[0]  = s3_len_ff;
   assign div_quo[0]  = '0;
   assign div_side[0] = s3_side_ff;

   // Row of division cells, one quotient bit each.
   for (genvar i = 0; i < T; i++) begin : g_div
      psd_div_cell #(.LW(LW), .QW(T), .SIDE_W(SIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (div_ctrl[i]),
         .rem_in   (div_rem[i]),
         .len_in   (div_len[i]),
         .quo_in   (div_quo[i]),
         .side_in  (div_side[i]),
         .ctrl_out (div_ctrl[i+1]),
         .rem_out  (div_rem[i+1]),
         .len_out  (div_len[i+1]),
         .quo_out  (div_quo[i+1]),
         .side_out (div_side[i+1])
      );
   end

   // Stage E1: scale the direction by t.
   logic [T:0]            t_val;
   logic signed [DW-1:0]  d_dx, d_dy, d_px, d_py;

   assign t_val = div_ctrl[T].t_one ? T_ONE : {1'b0, div_quo[T]};
   assign {d_dx, d_dy, d_px, d_py} = div_side[T];

   psd_pkg::psd_ctrl_type e1_ctrl_ff;
   logic [T:0]            e1_t_ff;
   logic signed [TPW-1:0] e1_tdx_ff, e1_tdy_ff;
   logic signed [DW-1:0]  e1_px_ff, e1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ctrl_ff <= '0;
      end else if (en) begin
         e1_ctrl_ff <= div_ctrl[T];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_t_ff   <= t_val;
         e1_tdx_ff <= $signed({1'b0, t_val}) * d_dx;
         e1_tdy_ff <= $signed({1'b0, t_val}) * d_dy;
         e1_px_ff  <= d_px;
         e1_py_ff  <= d_py;
      end
   end

   // Stage E2: error vector magnitudes.
   logic signed [EW-1:0] ex, ey;

   assign ex = EW'(e1_tdx_ff) - (EW'(e1_px_ff) <<< T);
   assign ey = EW'(e1_tdy_ff) - (EW'(e1_py_ff) <<< T);

   psd_pkg::psd_ctrl_type e2_ctrl_ff;
   logic [T:0]            e2_t_ff;
   logic [MW-1:0]         e2_magx_ff, e2_magy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_ctrl_ff <= '0;
      end else if (en) begin
         e2_ctrl_ff <= e1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e2_t_ff    <= e1_t_ff;
         e2_magx_ff <= ex[EW-1] ? MW'(-ex) : MW'(ex);
         e2_magy_ff <= ey[EW-1] ? MW'(-ey) : MW'(ey);
      end
   end

   // Stage E3: squares as half-width partial products.
   logic [MW-H-1:0] xh, yh;
   logic [H-1:0]    xl, yl;

   assign xh = e2_magx_ff[MW-1:H];
   assign xl = e2_magx_ff[H-1:0];
   assign yh = e2_magy_ff[MW-1:H];
   assign yl = e2_magy_ff[H-1:0];

   psd_pkg::psd_ctrl_type e3_ctrl_ff;
   logic [T:0]            e3_t_ff;
   logic [2*H-1:0]        e3_xhh_ff, e3_xhl_ff, e3_xll_ff;
   logic [2*H-1:0]        e3_yhh_ff, e3_yhl_ff, e3_yll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e3_ctrl_ff <= '0;
      end else if (en) begin
         e3_ctrl_ff <= e2_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e3_t_ff   <= e2_t_ff;
         e3_xhh_ff <= (2*H)'(xh * xh);
         e3_xhl_ff <= (2*H)'(xh * xl);
         e3_xll_ff <= (2*H)'(xl * xl);
         e3_yhh_ff <= (2*H)'(yh * yh);
         e3_yhl_ff <= (2*H)'(yh * yl);
         e3_yll_ff <= (2*H)'(yl * yl);
      end
   end

   // Stage E4: squared distance; drop the fraction bits of t squared.
   logic [D2W-1:0] d2;

   assign d2 = (D2W'(e3_xhh_ff) << (2*H)) + (D2W'(e3_xhl_ff) << (H+1)) + D2W'(e3_xll_ff)
             + (D2W'(e3_yhh_ff) << (2*H)) + (D2W'(e3_yhl_ff) << (H+1)) + D2W'(e3_yll_ff);

   psd_pkg::psd_ctrl_type sq_ctrl [0:RW];
   logic [2*RW-1:0]       sq_rad  [0:RW];
   logic [RW+1:0]         sq_rem  [0:RW];
   logic [RW-1:0]         sq_root [0:RW];
   logic [T:0]            sq_side [0:RW];
   psd_pkg::psd_ctrl_type e4_ctrl_ff;
   logic [T:0]            e4_t_ff;
   logic [2*RW-1:0]       e4_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e4_ctrl_ff <= '0;
      end else if (en) begin
         e4_ctrl_ff <= e3_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e4_t_ff   <= e3_t_ff;
         e4_rad_ff <= d2[D2W-1:2*T];
      end
   end

   assign sq_ctrl[0] = e4_ctrl_ff;
   assign sq_rad[0]  = e4_rad_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = e4_t_ff;

   // Row of square root cells, one root bit each.
   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      psd_sqrt_cell #(.RW(RW), .SIDE_W(T+1)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (sq_ctrl[j]),
         .rad_in   (sq_rad[j]),
         .rem_in   (sq_rem[j]),
         .root_in  (sq_root[j]),
         .side_in  (sq_side[j]),
         .ctrl_out (sq_ctrl[j+1]),
         .rad_out  (sq_rad[j+1]),
         .rem_out  (sq_rem[j+1]),
         .root_out (sq_root[j+1]),
         .side_out (sq_side[j+1])
      );
   end

   // Output register with saturation of the distance.
   logic [CW:0] dist_ff;
   logic [T:0]  t_out_ff;
   logic        degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sq_ctrl[RW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff  <= (sq_root[RW] > RW'(DIST_MAX)) ? DIST_MAX : sq_root[RW][CW:0];
         t_out_ff <= sq_side[RW];
         degen_ff <= sq_ctrl[RW].degenerate;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.distance   = dist_ff;
   assign rsp_chan.param_t    = t_out_ff;
   assign rsp_chan.degenerate = degen_ff;

endmodule

/* hdl/psd_div_cell.sv */
// One restoring division step: produces one quotient bit per cell.
module psd_div_cell #(
   parameter int LW     = 50,
   parameter int QW     = 16,
   parameter int SIDE_W = 100
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  psd_pkg::psd_ctrl_type ctrl_in,
   input  logic [LW-1:0]        rem_in,
   input  logic [LW-1:0]        len_in,
   input  logic [QW-1:0]        quo_in,
   input  logic [SIDE_W-1:0]    side_in,
   output psd_pkg::psd_ctrl_type ctrl_out,
   output logic [LW-1:0]        rem_out,
   output logic [LW-1:0]        len_out,
   output logic [QW-1:0]        quo_out,
   output logic [SIDE_W-1:0]    side_out
);

   psd_pkg::psd_ctrl_type ctrl_ff;
   logic [LW-1:0]         rem_ff, rem_in_n, len_ff;
   logic [QW-1:0]         quo_ff, quo_in_n;
   logic [SIDE_W-1:0]     side_ff;
   logic [LW:0]           shifted;

   // Shift the partial remainder and subtract the divisor where it fits.
   always_comb begin
      shifted = {rem_in, 1'b0};
      if (shifted >= {1'b0, len_in}) begin
         rem_in_n = LW'(shifted - {1'b0, len_in});
         quo_in_n = {quo_in[QW-2:0], 1'b1};
      end else begin
         rem_in_n = shifted[LW-1:0];
         quo_in_n = {quo_in[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in_n;
         len_ff  <= len_in;
         quo_ff  <= quo_in_n;
         side_ff <= side_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign len_out  = len_ff;
   assign quo_out  = quo_ff;
   assign side_out = side_ff;

endmodule

/* hdl/psd_sqrt_cell.sv */
// One digit-by-digit square root step: produces one root bit per cell.
module psd_sqrt_cell #(
   parameter int RW     = 29,
   parameter int SIDE_W = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  psd_pkg::psd_ctrl_type ctrl_in,
   input  logic [2*RW-1:0]       rad_in,
   input  logic [RW+1:0]         rem_in,
   input  logic [RW-1:0]         root_in,
   input  logic [SIDE_W-1:0]     side_in,
   output psd_pkg::psd_ctrl_type ctrl_out,
   output logic [2*RW-1:0]       rad_out,
   output logic [RW+1:0]         rem_out,
   output logic [RW-1:0]         root_out,
   output logic [SIDE_W-1:0]     side_out
);

   psd_pkg::psd_ctrl_type ctrl_ff;
   logic [2*RW-1:0]       rad_ff;
   logic [RW+1:0]         rem_ff, rem_in_n;
   logic [RW-1:0]         root_ff, root_in_n;
   logic [SIDE_W-1:0]     side_ff;
   logic [RW+3:0]         trial_rem;
   logic [RW+3:0]         trial;

   // Bring down the next two radicand bits and test the trial subtrahend.
   always_comb begin
      trial_rem = {rem_in, rad_in[2*RW-1 -: 2]};
      trial     = {2'b00, root_in, 2'b01};
      if (trial_rem >= trial) begin
         rem_in_n  = (RW+2)'(trial_rem - trial);
         root_in_n = {root_in[RW-2:0], 1'b1};
      end else begin
         rem_in_n  = trial_rem[RW+1:0];
         root_in_n = {root_in[RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= {rad_in[2*RW-3:0], 2'b00};
         rem_ff  <= rem_in_n;
         root_ff <= root_in_n;
         side_ff <= side_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;

endmodule

/* hdl/psd_checker.sv */
// Port-level checks on the response channel.
module psd_checker #(
   parameter int COORD_WIDTH = 24,
   parameter int T_FRAC_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [COORD_WIDTH:0] rsp_distance,
   input logic [T_FRAC_BITS:0] rsp_param_t,
   input logic                 rsp_degenerate
);

   localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
                                 && $stable(rsp_param_t) && $stable(rsp_degenerate))
      else $error("stalled response changed");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The projection parameter never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_param_t <= T_ONE)
      else $error("param_t above one");

   // A degenerate segment always reports t of zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_param_t == '0)
      else $error("degenerate segment with nonzero param_t");

endmodule

bind point_segment_distance_unit psd_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .T_FRAC_BITS (T_FRAC_BITS)
) u_psd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_distance   (rsp_chan.distance),
   .rsp_param_t    (rsp_chan.param_t),
   .rsp_degenerate (rsp_chan.degenerate)
);

/* tb/tb_point_segment_distance_unit.sv */
module tb_point_segment_distance_unit;

   localparam int CW = 24;
   localparam int TF = 16;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
      logic signed [CW-1:0] query_x;
      logic signed [CW-1:0] query_y;
   } query_type;

   typedef struct packed {
      logic [CW:0] distance;
      logic [TF:0] param_t;
      logic        degenerate;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psd_req_if #(.COORD_WIDTH(CW)) req_chan ();
   psd_rsp_if #(.COORD_WIDTH(CW), .T_FRAC_BITS(TF)) rsp_chan ();

   point_segment_distance_unit #(.COORD_WIDTH(CW), .T_FRAC_BITS(TF)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   query_type  pending_queries[$];
   answer_type expected_answers[$];
   int         error_count = 0;
   int         idle_cycles = 0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         stall_phase = 0;
   bit         stimulus_done = 1'b0;

   // Integer square root, floor, of a value up to 128 bits.
   function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = 128'(c) * 128'(c);
         if (sq <= s) begin
            r = c;
         end
      end
      return r;
   endfunction

   // Nearest point on the segment and distance to the query point.
   function automatic answer_type segment_distance(input query_type q);
      answer_type         a;
      logic signed [63:0] dx, dy, px, py;
      logic signed [127:0] dot, len2, ex, ey, t;
      logic [127:0]       d2;
      logic [63:0]        root;
      dx   = 64'(q.end_x) - 64'(q.start_x);
      dy   = 64'(q.end_y) - 64'(q.start_y);
      px   = 64'(q.query_x) - 64'(q.start_x);
      py   = 64'(q.query_y) - 64'(q.start_y);
      dot  = 128'(px) * 128'(dx) + 128'(py) * 128'(dy);
      len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      a.degenerate = (len2 == 0);
      if (len2 == 0 || dot <= 0) begin
         t = 0;
      end else if (dot >= len2) begin
         t = 128'sd1 <<< TF;
      end else begin
         t = (dot <<< TF) / len2;
      end
      ex = t * 128'(dx) - (128'(px) <<< TF);
      ey = t * 128'(dy) - (128'(py) <<< TF);
      if (ex < 0) ex = -ex;
      if (ey < 0) ey = -ey;
      d2   = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey);
      root = floor_sqrt(d2) >> TF;
      a.distance = (root > 64'((1 << (CW + 1)) - 1)) ? '1 : root[CW:0];
      a.param_t  = t[TF:0];
      return a;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return {1'b1, {(CW-1){1'b0}}};
         1:       return {1'b0, {(CW-1){1'b1}}};
         2:       return CW'($signed($urandom_range(0, 4000)) - 2000);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic query_type rand_query();
      query_type q;
      q.start_x = rand_coord();
      q.start_y = rand_coord();
      q.end_x   = rand_coord();
      q.end_y   = rand_coord();
      q.query_x = rand_coord();
      q.query_y = rand_coord();
      // Some segments collapse to a single point.
      if ($urandom_range(0, 15) == 0) begin
         q.end_x = q.start_x;
         q.end_y = q.start_y;
      end
      return q;
   endfunction

   function automatic query_type make_query(input int ax, ay, bx, by, qx, qy);
      query_type q;
      q.start_x = CW'(ax);
      q.start_y = CW'(ay);
      q.end_x   = CW'(bx);
      q.end_y   = CW'(by);
      q.query_x = CW'(qx);
      q.query_y = CW'(qy);
      return q;
   endfunction

   // Directed cases, then random ones.
   initial begin
      int mn, mx;
      mn = -(1 << (CW - 1));
      mx = (1 << (CW - 1)) - 1;
      pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0));
      pending_queries.push_back(make_query(100, 200, 100, 200, -300, 50));
      pending_queries.push_back(make_query(mn, mn, mn, mn, mx, mx));
      pending_queries.push_back(make_query(mn, mn, mx, mx, mx, mn));
      pending_queries.push_back(make_query(mx, mx, mn, mn, mn, mx));
      pending_queries.push_back(make_query(mn, mx, mx, mn, mn, mn));
      pending_queries.push_back(make_query(0, 0, 4096, 0, -4096, 4096));
      pending_queries.push_back(make_query(0, 0, 4096, 0, 8192, 4096));
      pending_queries.push_back(make_query(0, 0, 4096, 0, 4096, 4096));
      pending_queries.push_back(make_query(0, 0, 4096, 0, 2048, -4096));
      pending_queries.push_back(make_query(0, 0, 3, 7, 1, 1));
      pending_queries.push_back(make_query(0, 0, 1, 0, 0, 0));
      pending_queries.push_back(make_query(mn, 0, mx, 0, 0, mx));
      pending_queries.push_back(make_query(0, mn, 0, mx, mn, 0));
      pending_queries.push_back(make_query(-1, -1, 1, 1, -1, 1));
      pending_queries.push_back(make_query(mx, mx, mx, mx, mn, mn));
      for (int i = 0; i < 1100; i++) begin
         pending_queries.push_back(rand_query());
      end
   end

   // Driver: bursts of back-to-back transactions separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.start_x <= '0;
         req_chan.start_y <= '0;
         req_chan.end_x   <= '0;
         req_chan.end_y   <= '0;
         req_chan.query_x <= '0;
         req_chan.query_y <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_answers.push_back(segment_distance({req_chan.start_x,
               req_chan.start_y, req_chan.end_x, req_chan.end_y,
               req_chan.query_x, req_chan.query_y}));
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_queries.size() > 0) begin
            query_type q;
            q = pending_queries.pop_front();
            req_chan.valid   <= 1'b1;
            req_chan.start_x <= q.start_x;
            req_chan.start_y <= q.start_y;
            req_chan.end_x   <= q.end_x;
            req_chan.end_y   <= q.end_y;
            req_chan.query_x <= q.query_x;
            req_chan.query_y <= q.query_y;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_chan.valid <= 1'b0;
            stimulus_done  <= 1'b1;
         end
      end
   end

   // Receiver stall pattern: alternating free-running and choppy phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 600;
         if (stall_phase < 200) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_phase < 400) begin
            rsp_chan.ready <= ($urandom_range(0, 2) != 0);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 5) == 0);
         end
      end
   end

   // Monitor: compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: result with none expected: dist=%0d t=%0d deg=%0b", $time,
                     rsp_chan.distance, rsp_chan.param_t, rsp_chan.degenerate);
            error_count <= error_count + 1;
         end else begin
            answer_type e;
            bit         bad;
            e   = expected_answers.pop_front();
            bad = 1'b0;
            if (rsp_chan.distance !== e.distance) begin
               $display("%0t: distance expected %0d actual %0d", $time,
                        e.distance, rsp_chan.distance);
               bad = 1'b1;
            end
            if (rsp_chan.param_t !== e.param_t) begin
               $display("%0t: param_t expected %0d actual %0d", $time,
                        e.param_t, rsp_chan.param_t);
               bad = 1'b1;
            end
            if (rsp_chan.degenerate !== e.degenerate) begin
               $display("%0t: degenerate expected %0b actual %0b", $time,
                        e.degenerate, rsp_chan.degenerate);
               bad = 1'b1;
            end
            if (bad) begin
               error_count <= error_count + 1;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reset, then wait for the stimulus to drain or for the watchdog, and finish the run.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stimulus_done && expected_answers.size() == 0);
            repeat (100) @(posedge clock);
         end
         wait (idle_cycles >= STALL_LIMIT);
      join_any
      if (idle_cycles < STALL_LIMIT && error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
